// ===== src/bbsf_pkg.sv =====
// Shared types, constants and helpers for the bounded byte stream FIFO.
// Depends on nothing; imported by every module of the block.
package bbsf_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int CAP_W  = 13;
	localparam int STAT_W = 13;
	localparam int TOT_W  = 64;
	localparam int EXT_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_PUSH  = op_t'(0);
	localparam op_t OP_POP   = op_t'(1);
	localparam op_t OP_CLOSE = op_t'(2);
	localparam op_t OP_ERROR = op_t'(3);

	typedef logic [APB_AW-3:0] reg_idx_t;
	localparam reg_idx_t REG_CAPACITY = reg_idx_t'(0);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

	typedef struct packed {
		logic              wr_en;
		logic [PTR_W-1:0]  wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              rd_en;
		logic [PTR_W-1:0]  rd_addr;
	} ram_req_t;

	// Advance a ring position by at most RING_DEPTH entries.
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
			input logic [CNT_W-1:0] by);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - PTR_W){1'b0}}, ptr} + {1'b0, by};
		if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(RING_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ===== src/bbsf_cfg.sv =====
// APB-style configuration register for the byte FIFO: the capacity limit.
// Depends on bbsf_pkg.
module bbsf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbsf_pkg::APB_AW-1:0] paddr,
	input  logic [bbsf_pkg::APB_DW-1:0] pwdata,
	output logic [bbsf_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output logic [bbsf_pkg::CAP_W-1:0]  capacity
);
	import bbsf_pkg::*;

	logic [CAP_W-1:0] cap_q;
	reg_idx_t         reg_idx;

	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CAPACITY: prdata = APB_DW'(cap_q);
			default:      prdata = '0;
		endcase
	end

	assign capacity = cap_q;

endmodule

// ===== src/bbsf_ram.sv =====
// Byte ring storage: one write port and one registered read port.
// Depends on bbsf_pkg for depth, widths and the request struct.
module bbsf_ram (
	input  logic                        clk,
	input  bbsf_pkg::ram_req_t          req,
	output logic [bbsf_pkg::BYTE_W-1:0] rd_data
);
	import bbsf_pkg::*;

	logic [BYTE_W-1:0] mem [RING_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/bbsf_core.sv =====
// Stream state, counters and result register of the byte FIFO.
// Depends on bbsf_pkg; drives the ring through a ram_req_t request.
module bbsf_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bbsf_pkg::CAP_W-1:0]  capacity,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bbsf_pkg::OP_W-1:0]   op,
	input  logic [bbsf_pkg::BYTE_W-1:0] data_byte,
	input  logic [bbsf_pkg::LEN_W-1:0]  pop_length,
	output bbsf_pkg::ram_req_t          ram_req,
	input  logic [bbsf_pkg::BYTE_W-1:0] ram_rd_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic [bbsf_pkg::BYTE_W-1:0] next_byte,
	output logic                        next_valid,
	output logic [bbsf_pkg::STAT_W-1:0] buffered_count,
	output logic [bbsf_pkg::STAT_W-1:0] space_left,
	output logic [bbsf_pkg::TOT_W-1:0]  total_pushed,
	output logic [bbsf_pkg::TOT_W-1:0]  total_popped,
	output logic                        closed,
	output logic                        finished,
	output logic                        error
);
	import bbsf_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [TOT_W-1:0]  pushed_q;
	logic [TOT_W-1:0]  popped_q;
	logic              closed_q;
	logic              error_q;
	logic              out_valid_q;
	logic              accepted_q;
	logic              byp_q;
	logic [BYTE_W-1:0] byp_byte_q;

	logic              in_fire;
	logic [EXT_W-1:0]  cap_ext;
	logic [CNT_W-1:0]  eff_cap;
	logic              push_ok;
	logic [CNT_W-1:0]  take;
	logic [CNT_W-1:0]  count_n;
	logic [PTR_W-1:0]  rd_ptr_n;
	logic [PTR_W-1:0]  wr_ptr_n;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Clamp the programmed capacity to the ring depth.
	assign cap_ext = EXT_W'(capacity);
	assign eff_cap = (cap_ext > EXT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : CNT_W'(capacity);

	always_comb begin
		push_ok = 1'b0;
		take    = '0;
		case (op)
			OP_PUSH: begin
				push_ok = !closed_q && (count_q < eff_cap);
			end
			OP_POP: begin
				take = (EXT_W'(pop_length) < EXT_W'(count_q)) ? CNT_W'(pop_length) : count_q;
			end
			default: begin
			end
		endcase
	end

	assign count_n  = count_q + CNT_W'(push_ok) - take;
	assign rd_ptr_n = ring_add(rd_ptr_q, take);
	assign wr_ptr_n = ring_add(wr_ptr_q, CNT_W'(push_ok));

	// Read the head after this item; an empty ring gets the pushed byte by bypass.
	always_comb begin
		ram_req.wr_en   = in_fire && push_ok;
		ram_req.wr_addr = wr_ptr_q;
		ram_req.wr_data = data_byte;
		ram_req.rd_en   = in_fire;
		ram_req.rd_addr = rd_ptr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			pushed_q    <= '0;
			popped_q    <= '0;
			closed_q    <= 1'b0;
			error_q     <= 1'b0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			byp_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_n;
				rd_ptr_q    <= rd_ptr_n;
				wr_ptr_q    <= wr_ptr_n;
				pushed_q    <= pushed_q + TOT_W'(push_ok);
				popped_q    <= popped_q + TOT_W'(take);
				closed_q    <= closed_q || (op == OP_CLOSE);
				error_q     <= error_q || (op == OP_ERROR);
				out_valid_q <= 1'b1;
				accepted_q  <= push_ok;
				byp_q       <= push_ok && (count_q == '0);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byp_byte_q <= data_byte;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign next_valid     = (count_q != '0);
	assign next_byte      = next_valid ? (byp_q ? byp_byte_q : ram_rd_data) : '0;
	assign buffered_count = STAT_W'(count_q);
	assign space_left     = (eff_cap > count_q) ? STAT_W'(eff_cap - count_q) : '0;
	assign total_pushed   = pushed_q;
	assign total_popped   = popped_q;
	assign closed         = closed_q;
	assign finished       = closed_q && (count_q == '0);
	assign error          = error_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RING_DEPTH))
		else $error("held count exceeds ring depth");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(pushed_q - popped_q))
		else $error("held count disagrees with byte counters");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q == ring_add(rd_ptr_q, count_q))
		else $error("write pointer disagrees with read pointer and count");

	a_push_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && push_ok |=> pushed_q == $past(pushed_q) + TOT_W'(1))
		else $error("stored push did not advance pushed counter");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(pushed_q) && $stable(popped_q) && $stable(rd_ptr_q))
		else $error("stream state changed without an item");

endmodule

// ===== src/bounded_byte_stream_fifo.sv =====
// Bounded byte FIFO with writer close and error marks, one item per operation.
// An item's result is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle if out_ready; ring: one read, at most one write.
// Reset clears counters, pointers and marks and sets capacity to 4096;
// ring contents are not cleared, and no unwritten byte reaches next_byte.
module bounded_byte_stream_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbsf_pkg::APB_AW-1:0] paddr,
	input  logic [bbsf_pkg::APB_DW-1:0] pwdata,
	output logic [bbsf_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bbsf_pkg::OP_W-1:0]   op,
	input  logic [bbsf_pkg::BYTE_W-1:0] data_byte,
	input  logic [bbsf_pkg::LEN_W-1:0]  pop_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic [bbsf_pkg::BYTE_W-1:0] next_byte,
	output logic                        next_valid,
	output logic [bbsf_pkg::STAT_W-1:0] buffered_count,
	output logic [bbsf_pkg::STAT_W-1:0] space_left,
	output logic [bbsf_pkg::TOT_W-1:0]  total_pushed,
	output logic [bbsf_pkg::TOT_W-1:0]  total_popped,
	output logic                        closed,
	output logic                        finished,
	output logic                        error
);
	import bbsf_pkg::*;

	logic [CAP_W-1:0]  capacity;
	ram_req_t          ram_req;
	logic [BYTE_W-1:0] ram_rd_data;

	bbsf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	bbsf_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd_data)
	);

	bbsf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity       (capacity),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.data_byte      (data_byte),
		.pop_length     (pop_length),
		.ram_req        (ram_req),
		.ram_rd_data    (ram_rd_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.next_byte      (next_byte),
		.next_valid     (next_valid),
		.buffered_count (buffered_count),
		.space_left     (space_left),
		.total_pushed   (total_pushed),
		.total_popped   (total_popped),
		.closed         (closed),
		.finished       (finished),
		.error          (error)
	);

endmodule

// ===== sim/bounded_byte_stream_fifo_tb.sv =====
// Self-checking testbench for bounded_byte_stream_fifo: directed and random push, pop,
// close and error items, with an in-order status predictor and random stalls.
// Depends on bbsf_pkg and the bounded_byte_stream_fifo RTL.
module bounded_byte_stream_fifo_tb;
	import bbsf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_GAP   = 4;
	localparam int PHASE_ITEMS = 40;
	localparam int FILL_CAP    = 24;

	typedef struct {
		logic              stored;
		logic [BYTE_W-1:0] head_byte;
		logic              head_valid;
		logic [STAT_W-1:0] held;
		logic [STAT_W-1:0] room;
		logic [TOT_W-1:0]  pushed;
		logic [TOT_W-1:0]  popped;
		logic              closed_exp;
		logic              finished_exp;
		logic              is_error;
	} fifo_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	op_t                  op;
	logic [BYTE_W-1:0]    data_byte;
	logic [LEN_W-1:0]     pop_length;
	logic                 out_valid;
	logic                 out_ready;
	logic                 accepted;
	logic [BYTE_W-1:0]    next_byte;
	logic                 next_valid;
	logic [STAT_W-1:0]    buffered_count;
	logic [STAT_W-1:0]    space_left;
	logic [TOT_W-1:0]     total_pushed;
	logic [TOT_W-1:0]     total_popped;
	logic                 closed;
	logic                 finished;
	logic                 error;

	// predictor state
	logic [BYTE_W-1:0]    ring_copy [RING_DEPTH];
	logic [TOT_W-1:0]     pushed_total;
	logic [TOT_W-1:0]     popped_total;
	int unsigned          head_pos;
	logic                 closed_mark;
	logic                 error_mark;
	logic [CAP_W-1:0]     cap_reg;

	fifo_status_t         status_q [$];
	int unsigned          mismatch_cnt;
	int unsigned          cycle_cnt;
	bit                   idling_on;

	bounded_byte_stream_fifo u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.data_byte      (data_byte),
		.pop_length     (pop_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.next_byte      (next_byte),
		.next_valid     (next_valid),
		.buffered_count (buffered_count),
		.space_left     (space_left),
		.total_pushed   (total_pushed),
		.total_popped   (total_popped),
		.closed         (closed),
		.finished       (finished),
		.error          (error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("bounded_byte_stream_fifo_tb failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [TOT_W-1:0] got,
			input logic [TOT_W-1:0] want);
		mismatch_cnt++;
		$display("[%0t] mismatch %0d on %s: got 0x%0h, want 0x%0h", $realtime, mismatch_cnt,
			what, got, want);
	endtask

	// Apply one item to the mirrored FIFO and queue the status it must produce.
	function automatic void apply_fifo_op(input op_t opc, input logic [BYTE_W-1:0] din,
			input logic [LEN_W-1:0] len);
		fifo_status_t st;
		logic [TOT_W-1:0] held;
		logic [TOT_W-1:0] cap_eff;
		logic [TOT_W-1:0] take;
		held = pushed_total - popped_total;
		cap_eff = (cap_reg > RING_DEPTH) ? TOT_W'(RING_DEPTH) : TOT_W'(cap_reg);
		st.stored = 1'b0;
		case (opc)
			OP_PUSH: begin
				if (!closed_mark && held < cap_eff) begin
					ring_copy[(head_pos + int'(held)) % RING_DEPTH] = din;
					pushed_total = pushed_total + 1;
					st.stored = 1'b1;
				end
			end
			OP_POP: begin
				take = (TOT_W'(len) < held) ? TOT_W'(len) : held;
				popped_total = popped_total + take;
				head_pos = (head_pos + int'(take)) % RING_DEPTH;
			end
			OP_CLOSE: closed_mark = 1'b1;
			default: error_mark = 1'b1;
		endcase
		held = pushed_total - popped_total;
		st.head_valid   = (held != 0);
		st.head_byte    = st.head_valid ? ring_copy[head_pos] : '0;
		st.held         = held[STAT_W-1:0];
		st.room         = (cap_eff > held) ? STAT_W'(cap_eff - held) : '0;
		st.pushed       = pushed_total;
		st.popped       = popped_total;
		st.closed_exp   = closed_mark;
		st.finished_exp = closed_mark && (held == 0);
		st.is_error     = error_mark;
		status_q.push_back(st);
	endfunction

	// Compare every delivered status with the oldest prediction.
	always @(posedge clk) begin
		fifo_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				flag_mismatch("unexpected result, buffered_count", TOT_W'(buffered_count), '0);
			end else begin
				want = status_q.pop_front();
				if (accepted !== want.stored)
					flag_mismatch("accepted", TOT_W'(accepted), TOT_W'(want.stored));
				if (next_byte !== want.head_byte)
					flag_mismatch("next_byte", TOT_W'(next_byte), TOT_W'(want.head_byte));
				if (next_valid !== want.head_valid)
					flag_mismatch("next_valid", TOT_W'(next_valid), TOT_W'(want.head_valid));
				if (buffered_count !== want.held)
					flag_mismatch("buffered_count", TOT_W'(buffered_count), TOT_W'(want.held));
				if (space_left !== want.room)
					flag_mismatch("space_left", TOT_W'(space_left), TOT_W'(want.room));
				if (total_pushed !== want.pushed)
					flag_mismatch("total_pushed", total_pushed, want.pushed);
				if (total_popped !== want.popped)
					flag_mismatch("total_popped", total_popped, want.popped);
				if (closed !== want.closed_exp)
					flag_mismatch("closed", TOT_W'(closed), TOT_W'(want.closed_exp));
				if (finished !== want.finished_exp)
					flag_mismatch("finished", TOT_W'(finished), TOT_W'(want.finished_exp));
				if (error !== want.is_error)
					flag_mismatch("error", TOT_W'(error), TOT_W'(want.is_error));
			end
		end
	end

	// Result-side stalls: bursts low, random stretches high.
	initial begin : sink_pacing
		out_ready = 1'b0;
		forever begin
			if (idling_on && $urandom_range(0, 7) == 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat ($urandom_range(0, 17)) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			repeat ($urandom_range(0, 20)) @(negedge clk);
		end
	end

	task automatic send_item(input op_t opc, input logic [BYTE_W-1:0] din,
			input logic [LEN_W-1:0] len);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat ($urandom_range(0, 17)) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		op         <= opc;
		data_byte  <= din;
		pop_length <= len;
		do @(posedge clk); while (!in_ready);
		apply_fifo_op(opc, din, len);
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] din);
		send_item(OP_PUSH, din, LEN_W'($urandom()));
	endtask

	task automatic pop_bytes(input logic [LEN_W-1:0] len);
		send_item(OP_POP, BYTE_W'($urandom()), len);
	endtask

	task automatic send_mark(input op_t opc);
		send_item(opc, BYTE_W'($urandom()), LEN_W'($urandom()));
	endtask

	// Hold off the sender until every predicted status has been delivered.
	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= {(APB_DW - CAP_W)'($urandom()), cap};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cap_reg = cap;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic test_basic_ops();
		pop_bytes('0);
		pop_bytes('1);
		push_byte(8'h00);
		push_byte(8'hFF);
		pop_bytes('0);
		pop_bytes(16'd1);
		push_byte(8'hA5);
		pop_bytes('1);
	endtask

	task automatic test_capacity_limits();
		write_capacity(CAP_W'(1));
		push_byte(8'h3C);
		push_byte(8'hC3);
		pop_bytes(16'd1);
		write_capacity('0);
		push_byte(8'h11);
		write_capacity('1);
		push_byte(8'h22);
		pop_bytes('1);
	endtask

	// Lower capacity below the held count: nothing lost, pushes dropped until held < capacity.
	task automatic test_capacity_shrink();
		write_capacity(CAP_RESET);
		repeat (5) push_byte(BYTE_W'($urandom()));
		write_capacity(CAP_W'(2));
		push_byte(BYTE_W'($urandom()));
		pop_bytes(16'd4);
		push_byte(BYTE_W'($urandom()));
		pop_bytes('1);
	endtask

	// Fill a small capacity, overflow it, then refill after a partial pop.
	task automatic test_fill_overflow();
		int unsigned k;
		write_capacity(CAP_W'(FILL_CAP));
		repeat (FILL_CAP + 2) push_byte(BYTE_W'($urandom()));
		k = $urandom_range(1, FILL_CAP - 4);
		pop_bytes(LEN_W'(k));
		repeat (k + 3) push_byte(BYTE_W'($urandom()));
		pop_bytes('1);
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] cap;
		logic [LEN_W-1:0] len;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cap = CAP_W'(1);
				1: cap = CAP_W'(2);
				2: cap = CAP_W'($urandom_range(3, 16));
				3: cap = CAP_RESET;
				4: cap = CAP_W'($urandom_range(1, 64));
				5: cap = '0;
				6: cap = '1;
				default: cap = CAP_W'($urandom_range(4, 32));
			endcase
			write_capacity(cap);
			if (ph == 7)
				idling_on = 1'b0;
			repeat ((ph == 5) ? 10 : PHASE_ITEMS) begin
				if ($urandom_range(0, 59) == 0)
					wait_drained();
				if ($urandom_range(0, 99) < 55) begin
					push_byte(BYTE_W'($urandom()));
				end else begin
					case ($urandom_range(0, 9))
						0: len = '0;
						1: len = '1;
						2: len = LEN_W'($urandom());
						default: len = LEN_W'($urandom_range(1, 4));
					endcase
					pop_bytes(len);
				end
			end
		end
	endtask

	// Error only reports; close blocks pushes for good, so this runs last.
	task automatic test_error_and_close();
		push_byte(8'h81);
		push_byte(8'h7E);
		send_mark(OP_ERROR);
		send_mark(OP_ERROR);
		push_byte(8'h42);
		pop_bytes(16'd1);
		send_mark(OP_CLOSE);
		push_byte(8'hE7);
		send_mark(OP_CLOSE);
		pop_bytes('1);
		pop_bytes('0);
		repeat (30) send_item(op_t'($urandom_range(0, 3)), BYTE_W'($urandom()),
			LEN_W'($urandom()));
	endtask

	initial begin : main
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		op           = OP_PUSH;
		data_byte    = '0;
		pop_length   = '0;
		pushed_total = '0;
		popped_total = '0;
		head_pos     = 0;
		closed_mark  = 1'b0;
		error_mark   = 1'b0;
		cap_reg      = CAP_RESET;
		idling_on    = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_basic_ops();
		test_capacity_limits();
		test_capacity_shrink();
		test_fill_overflow();
		test_random_traffic();
		test_error_and_close();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && status_q.size() == 0) begin
			$display("bounded_byte_stream_fifo_tb passed");
		end else begin
			$display("bounded_byte_stream_fifo_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/bbsf_pkg.sv
src/bbsf_cfg.sv
src/bbsf_ram.sv
src/bbsf_core.sv
src/bounded_byte_stream_fifo.sv
sim/bounded_byte_stream_fifo_tb.sv
